### src/lpd_pkg.sv
// Shared types and constants for the lidar packet decoder.
// No dependencies; used by every module of the block.
package lpd_pkg;

  // Framing bytes
  localparam logic [7:0] SYNC_BYTE  = 8'hFA;
  localparam logic [7:0] INDEX_LOW  = 8'hA0;
  localparam logic [7:0] INDEX_HIGH = 8'hF9;

  // Packet layout: body byte positions run 2..21
  localparam int POS_W      = 5;
  localparam logic [POS_W-1:0] POS_SUM_END  = 5'd20;  // words below this feed the checksum
  localparam logic [POS_W-1:0] POS_LAST     = 5'd21;
  localparam logic [POS_W-1:0] POS_SLOT_MIN = 5'd5;   // high byte of slot 0
  localparam logic [POS_W-1:0] POS_SLOT_MAX = 5'd17;  // high byte of slot 3

  // Reading high byte: invalid flag and distance bits
  localparam int FLAG_BAD_BIT = 7;
  localparam int HIGH_BITS    = 6;

  // Checksum
  localparam int ACC_W  = 27;
  localparam int FOLD_W = 15;
  localparam int WORD_W = 16;

  // Result fields
  localparam int SLOTS   = 4;
  localparam int SLOT_W  = 2;
  localparam int GROUP_W = 7;
  localparam int ANGLE_W = 9;
  localparam int RANGE_W = 14;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 9'd359;

  // Packet queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One checked packet: group, readings and their valid flags
  typedef struct packed {
    logic [GROUP_W-1:0]             group;
    logic [SLOTS-1:0]               ok;
    logic [SLOTS-1:0][RANGE_W-1:0]  rng;
  } pkt_rec_t;

  // Front to queue request
  typedef struct packed {
    logic     push;
    pkt_rec_t rec;
  } pkt_push_t;

endpackage

### src/lpd_front.sv
// Byte parser: sync hunt, group index check, body capture and checksum.
// Depends on lpd_pkg. Pushes one record per good packet with a valid reading.
module lpd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic                q_full,
  output lpd_pkg::pkt_push_t  req
);

  typedef enum logic [1:0] {PH_HUNT, PH_INDEX, PH_BODY} phase_t;

  phase_t                               phase;
  logic [lpd_pkg::POS_W-1:0]            pos;
  logic [lpd_pkg::ACC_W-1:0]            acc;
  logic [7:0]                           prev;
  logic [lpd_pkg::GROUP_W-1:0]          group;
  logic [lpd_pkg::SLOTS-1:0]            ok;
  logic [lpd_pkg::SLOTS-1:0][lpd_pkg::RANGE_W-1:0] rng;

  logic                                 accept;
  logic [lpd_pkg::POS_W-1:0]            p;
  logic [7:0]                           idx_off;
  logic [lpd_pkg::WORD_W-1:0]           word;
  logic [lpd_pkg::ACC_W-1:0]            acc_next;
  logic [lpd_pkg::FOLD_W:0]             fold_sum;
  logic                                 sum_match;
  logic                                 slot_hit;
  logic [lpd_pkg::SLOT_W-1:0]           slot;

  // Stall only when the queue cannot take a finished packet
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Body position and the word closed by an odd byte
  assign p        = pos + lpd_pkg::POS_W'(2);
  assign idx_off  = rx_byte - lpd_pkg::INDEX_LOW;
  assign word     = {rx_byte, prev};
  assign acc_next = {acc[lpd_pkg::ACC_W-2:0], 1'b0}
                  + {{(lpd_pkg::ACC_W-lpd_pkg::WORD_W){1'b0}}, word};

  // Fold to 15 bits and compare with trailing word
  assign fold_sum  = {1'b0, acc[lpd_pkg::FOLD_W-1:0]}
                   + {{(2*lpd_pkg::FOLD_W+1-lpd_pkg::ACC_W){1'b0}},
                      acc[lpd_pkg::ACC_W-1:lpd_pkg::FOLD_W]};
  assign sum_match = ({1'b0, fold_sum[lpd_pkg::FOLD_W-1:0]} == word);

  // Reading high bytes sit at positions 5, 9, 13, 17
  assign slot_hit = (p[1:0] == 2'b01) && (p >= lpd_pkg::POS_SLOT_MIN)
                 && (p <= lpd_pkg::POS_SLOT_MAX);
  assign slot     = p[3:2] - lpd_pkg::SLOT_W'(1);

  // Push request on the closing byte of a good packet
  always_comb begin
    req.push      = accept && (phase == PH_BODY) && (p == lpd_pkg::POS_LAST)
                 && sum_match && (|ok);
    req.rec.group = group;
    req.rec.ok    = ok;
    req.rec.rng   = rng;
  end

  // Parser state and capture registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos   <= '0;
      acc   <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == lpd_pkg::SYNC_BYTE) phase <= PH_INDEX;
        end
        PH_INDEX: begin
          if (rx_byte >= lpd_pkg::INDEX_LOW && rx_byte <= lpd_pkg::INDEX_HIGH) begin
            group <= idx_off[lpd_pkg::GROUP_W-1:0];
            acc   <= {{(lpd_pkg::ACC_W-lpd_pkg::WORD_W){1'b0}}, rx_byte, lpd_pkg::SYNC_BYTE};
            pos   <= '0;
            phase <= PH_BODY;
          end else begin
            phase <= PH_HUNT;
          end
        end
        PH_BODY: begin
          if (!p[0]) begin
            prev <= rx_byte;
          end else if (p < lpd_pkg::POS_SUM_END) begin
            acc <= acc_next;
          end
          if (slot_hit) begin
            rng[slot] <= {rx_byte[lpd_pkg::HIGH_BITS-1:0], prev};
            ok[slot]  <= !rx_byte[lpd_pkg::FLAG_BAD_BIT];
          end
          if (p == lpd_pkg::POS_LAST) begin
            phase <= PH_HUNT;
            pos   <= '0;
          end else begin
            pos <= pos + lpd_pkg::POS_W'(1);
          end
        end
        default: begin
          phase <= PH_HUNT;
        end
      endcase
    end
  end

endmodule

### src/lpd_queue.sv
// Short record queue between the parser and the reading emitter.
// Depends on lpd_pkg for the record type and depth.
module lpd_queue (
  input  logic                clk,
  input  logic                rst,
  input  lpd_pkg::pkt_push_t  req,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output lpd_pkg::pkt_rec_t   head
);

  lpd_pkg::pkt_rec_t            mem [lpd_pkg::QDEPTH];
  logic [lpd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lpd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lpd_pkg::QCNT_W-1:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign full      = (count == lpd_pkg::QCNT_W'(lpd_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  assign do_push   = req.push && !full;
  assign do_pop    = pop && not_empty;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= req.rec;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == lpd_pkg::QPTR_W'(lpd_pkg::QDEPTH-1)) ? '0
                : wr_ptr + lpd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == lpd_pkg::QPTR_W'(lpd_pkg::QDEPTH-1)) ? '0
                : rd_ptr + lpd_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + lpd_pkg::QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - lpd_pkg::QCNT_W'(1);
    end
  end

endmodule

### src/lpd_back.sv
// Reading emitter: walks the valid slots of one record, one result per cycle while the output is not stalled.
// Depends on lpd_pkg. Drives the registered output channel.
module lpd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_not_empty,
  input  lpd_pkg::pkt_rec_t           q_head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpd_pkg::ANGLE_W-1:0] angle_index,
  output logic [lpd_pkg::RANGE_W-1:0] range_value,
  output logic                        last_of_packet
);

  logic [lpd_pkg::SLOTS-1:0]   mask;
  lpd_pkg::pkt_rec_t           cur;
  logic [lpd_pkg::SLOT_W-1:0]  sel;
  logic [lpd_pkg::SLOTS-1:0]   mask_after;
  logic                        can_emit;

  // Lowest pending slot
  always_comb begin
    sel = '0;
    priority if (mask[0]) sel = 2'd0;
    else if (mask[1]) sel = 2'd1;
    else if (mask[2]) sel = 2'd2;
    else sel = 2'd3;
  end

  assign mask_after = mask & ~(lpd_pkg::SLOTS'(1) << sel);
  assign can_emit   = (mask != '0) && (!out_valid || out_ready);
  assign pop        = (mask == '0) && q_not_empty;

  // Record load and slot walk
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (pop) begin
      cur  <= q_head;
      mask <= q_head.ok;
    end else if (can_emit) begin
      mask <= mask_after;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_emit) begin
      out_valid      <= 1'b1;
      angle_index    <= {cur.group, sel};
      range_value    <= cur.rng[sel];
      last_of_packet <= (mask_after == '0);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### src/lidar_packet_decoder.sv
// Lidar packet decoder, top level: XV-11 style serial byte stream in,
// one request per valid distance reading out.
// Usage:
//   Input channel in_valid/in_ready carries rx_byte, one stream byte per
//   request. The parser hunts for 0xFA, checks the group index byte
//   (0xA0..0xF9), collects 20 body bytes and checks the folded checksum.
//   Output channel out_valid/out_ready carries angle_index, range_value and
//   last_of_packet; a good packet yields its valid readings in slot order,
//   last_of_packet marking the final one.
// Throughput: one byte per cycle on the input while the record queue is not
//   full. The emitter loads a packet record, then emits its valid readings,
//   and loads the next record only once the last reading has been emitted.
// Path: a packet's first reading passes the queue entry, the record load and
//   the output register after its closing byte is taken.
// Stall: a two-entry record queue separates the parser from the emitter.
//   A stalled receiver holds the output register; in_ready drops only when
//   the queue is full. Reset (rst, synchronous) returns the parser to the
//   hunt, empties the queue and clears out_valid. No clearing pass is needed.
module lidar_packet_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpd_pkg::ANGLE_W-1:0] angle_index,
  output logic [lpd_pkg::RANGE_W-1:0] range_value,
  output logic                        last_of_packet
);

  lpd_pkg::pkt_push_t req;
  lpd_pkg::pkt_rec_t  q_head;
  logic               q_full;
  logic               q_not_empty;
  logic               pop;

  // Parser front end
  lpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .req      (req)
  );

  // Record queue
  lpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Reading emitter
  lpd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .angle_index    (angle_index),
    .range_value    (range_value),
    .last_of_packet (last_of_packet)
  );

`ifndef SYNTH
  // A packet is never pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) req.push |-> !q_full)
    else $error("record pushed into full queue");

  // The emitter only pops a queue that holds a record
  assert property (@(posedge clk) disable iff (rst) pop |-> q_not_empty)
    else $error("pop from empty queue");

  // Angles stay within one revolution
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_index <= lpd_pkg::ANGLE_MAX))
    else $error("angle index out of range");
`endif

endmodule
